// ===== rtl/bcast_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcast_pkg
// Shared types, widths, register indexes and helpers of the broadcast index
// generator.
// ----------------------------------------------------------------------------
package bcast_pkg;

	localparam int NUM_DIMS       = 4;
	localparam int DIM_BITS       = $clog2(NUM_DIMS);
	localparam int EXTENT_BITS    = 12;
	localparam int ADDR_BITS      = 48;
	localparam int PROD1_BITS     = 2 * EXTENT_BITS;
	localparam int PROD0_BITS     = 3 * EXTENT_BITS;
	localparam int CFG_INDEX_BITS = 3;
	localparam int IN_TDATA_BITS  = 8;
	localparam int OUT_TDATA_BITS = 3 * ADDR_BITS;
	localparam int BUSY_BITS      = 2;

	// Cycles needed after a register write until the stride products settle.
	localparam logic [BUSY_BITS-1:0] BUSY_CYCLES = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT0     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT1     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT2     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT3     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_KEEP  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_KEEP = 3'd5;

	typedef logic [EXTENT_BITS-1:0] extent_t;
	typedef logic [ADDR_BITS-1:0]   addr_t;
	typedef logic [NUM_DIMS-1:0]    mask_t;

	typedef struct packed {
		extent_t [NUM_DIMS-1:0] extent;
		mask_t                  first_keep;
		mask_t                  second_keep;
	} cfg_t;

	// Stride of dimension d: product of the kept extents of all inner dimensions.
	typedef struct packed {
		addr_t [NUM_DIMS-1:0] first_stride;
		addr_t [NUM_DIMS-1:0] second_stride;
	} stride_t;

	typedef struct packed {
		logic  last;
		addr_t second_index;
		addr_t first_index;
		addr_t out_index;
	} result_t;

	// An extent of zero counts as one.
	function automatic extent_t eff_extent(input extent_t e);
		eff_extent = (e == '0) ? extent_t'(1) : e;
	endfunction

	// Factor a dimension adds to an operand's running stride product.
	function automatic extent_t kept_extent(input extent_t e, input logic kept);
		kept_extent = kept ? eff_extent(e) : extent_t'(1);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bcast_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcast_cfg
// Configuration registers and the operand stride products derived from them.
// ----------------------------------------------------------------------------
module bcast_cfg (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    wr_en,
	input  wire  [bcast_pkg::CFG_INDEX_BITS-1:0]   wr_index,
	input  wire  bcast_pkg::extent_t               wr_data,
	output bcast_pkg::cfg_t                        cfg,
	output bcast_pkg::stride_t                     strides,
	output logic                                   busy
);

	bcast_pkg::extent_t [bcast_pkg::NUM_DIMS-1:0] extent_q;
	bcast_pkg::mask_t                             first_keep_q;
	bcast_pkg::mask_t                             second_keep_q;
	logic [bcast_pkg::BUSY_BITS-1:0]              busy_q;

	bcast_pkg::extent_t                  f_fac3, f_fac2, f_fac1;
	bcast_pkg::extent_t                  s_fac3, s_fac2, s_fac1;
	logic [bcast_pkg::PROD1_BITS-1:0]    f_prod1_q, s_prod1_q;
	logic [bcast_pkg::PROD0_BITS-1:0]    f_prod0_q, s_prod0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < bcast_pkg::NUM_DIMS; d++) begin
				extent_q[d] <= bcast_pkg::extent_t'(1);
			end
			first_keep_q  <= '1;
			second_keep_q <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				bcast_pkg::REG_EXTENT0:     extent_q[0] <= wr_data;
				bcast_pkg::REG_EXTENT1:     extent_q[1] <= wr_data;
				bcast_pkg::REG_EXTENT2:     extent_q[2] <= wr_data;
				bcast_pkg::REG_EXTENT3:     extent_q[3] <= wr_data;
				bcast_pkg::REG_FIRST_KEEP:  first_keep_q <= wr_data[bcast_pkg::NUM_DIMS-1:0];
				bcast_pkg::REG_SECOND_KEEP: second_keep_q <= wr_data[bcast_pkg::NUM_DIMS-1:0];
				default: ;
			endcase
		end
	end

	// The stride products take two register stages; hold off input until done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (wr_en) begin
			busy_q <= bcast_pkg::BUSY_CYCLES;
		end else if (busy_q != '0) begin
			busy_q <= busy_q - 1'b1;
		end
	end

	assign f_fac3 = bcast_pkg::kept_extent(extent_q[3], first_keep_q[3]);
	assign f_fac2 = bcast_pkg::kept_extent(extent_q[2], first_keep_q[2]);
	assign f_fac1 = bcast_pkg::kept_extent(extent_q[1], first_keep_q[1]);
	assign s_fac3 = bcast_pkg::kept_extent(extent_q[3], second_keep_q[3]);
	assign s_fac2 = bcast_pkg::kept_extent(extent_q[2], second_keep_q[2]);
	assign s_fac1 = bcast_pkg::kept_extent(extent_q[1], second_keep_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_prod1_q <= bcast_pkg::PROD1_BITS'(1);
			s_prod1_q <= bcast_pkg::PROD1_BITS'(1);
			f_prod0_q <= bcast_pkg::PROD0_BITS'(1);
			s_prod0_q <= bcast_pkg::PROD0_BITS'(1);
		end else begin
			f_prod1_q <= bcast_pkg::PROD1_BITS'(f_fac3) * bcast_pkg::PROD1_BITS'(f_fac2);
			s_prod1_q <= bcast_pkg::PROD1_BITS'(s_fac3) * bcast_pkg::PROD1_BITS'(s_fac2);
			f_prod0_q <= bcast_pkg::PROD0_BITS'(f_prod1_q) * bcast_pkg::PROD0_BITS'(f_fac1);
			s_prod0_q <= bcast_pkg::PROD0_BITS'(s_prod1_q) * bcast_pkg::PROD0_BITS'(s_fac1);
		end
	end

	always_comb begin
		cfg.extent      = extent_q;
		cfg.first_keep  = first_keep_q;
		cfg.second_keep = second_keep_q;

		strides.first_stride[3]  = bcast_pkg::addr_t'(1);
		strides.first_stride[2]  = bcast_pkg::addr_t'(f_fac3);
		strides.first_stride[1]  = bcast_pkg::addr_t'(f_prod1_q);
		strides.first_stride[0]  = bcast_pkg::addr_t'(f_prod0_q);
		strides.second_stride[3] = bcast_pkg::addr_t'(1);
		strides.second_stride[2] = bcast_pkg::addr_t'(s_fac3);
		strides.second_stride[1] = bcast_pkg::addr_t'(s_prod1_q);
		strides.second_stride[0] = bcast_pkg::addr_t'(s_prod0_q);
	end

	assign busy = (busy_q != '0);

`ifndef SYNTHESIS
	a_busy_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> busy ##1 busy)
		else $error("stride settle window shorter than two cycles");

	a_prod_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en && !busy |-> f_prod0_q == bcast_pkg::PROD0_BITS'(f_prod1_q) *
			bcast_pkg::PROD0_BITS'(f_fac1))
		else $error("first operand stride product stale while idle");

	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !wr_en |=> ##1 !busy || $past(wr_en))
		else $error("settle window does not end");
`endif

endmodule
`default_nettype wire

// ===== rtl/bcast_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcast_step
// Mixed-radix position counter with incremental output and operand indices.
// ----------------------------------------------------------------------------
module bcast_step (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 clr,
	input  wire                 accept,
	input  wire                 restart,
	input  wire  bcast_pkg::cfg_t    cfg,
	input  wire  bcast_pkg::stride_t strides,
	output bcast_pkg::result_t  res
);

	bcast_pkg::extent_t [bcast_pkg::NUM_DIMS-1:0] pos_q, pos_cur, pos_next;
	bcast_pkg::addr_t   lin_q, fo_q, so_q;
	bcast_pkg::addr_t   lin_cur, fo_cur, so_cur;
	bcast_pkg::addr_t   lin_next, fo_next, so_next;
	bcast_pkg::addr_t   f_sub, s_sub;
	logic [bcast_pkg::NUM_DIMS-1:0] wrap;
	logic [bcast_pkg::DIM_BITS-1:0] carry;
	logic                           found;

	always_comb begin
		pos_cur = restart ? '0 : pos_q;
		lin_cur = restart ? '0 : lin_q;
		fo_cur  = restart ? '0 : fo_q;
		so_cur  = restart ? '0 : so_q;

		for (int d = 0; d < bcast_pkg::NUM_DIMS; d++) begin
			wrap[d] = ({1'b0, pos_cur[d]} + 1'b1) >=
				{1'b0, bcast_pkg::eff_extent(cfg.extent[d])};
		end

		// The innermost dimension that does not wrap takes the carry.
		found = 1'b0;
		carry = '0;
		for (int d = bcast_pkg::NUM_DIMS - 1; d >= 0; d--) begin
			if (!found && !wrap[d]) begin
				found = 1'b1;
				carry = bcast_pkg::DIM_BITS'(d);
			end
		end

		for (int d = 0; d < bcast_pkg::NUM_DIMS; d++) begin
			if (!found || bcast_pkg::DIM_BITS'(d) > carry) begin
				pos_next[d] = '0;
			end else if (bcast_pkg::DIM_BITS'(d) == carry) begin
				pos_next[d] = pos_cur[d] + 1'b1;
			end else begin
				pos_next[d] = pos_cur[d];
			end
		end

		// All inner dimensions sit at their maximum when the carry lands on a
		// dimension, so their contribution to an operand index is stride - 1.
		// A kept dimension then advances the index by one; a broadcast one
		// drops back by stride - 1.
		f_sub = cfg.first_keep[carry]  ? '0 : strides.first_stride[carry];
		s_sub = cfg.second_keep[carry] ? '0 : strides.second_stride[carry];

		lin_next = found ? lin_cur + 1'b1 : '0;
		fo_next  = found ? fo_cur + bcast_pkg::addr_t'(1) - f_sub : '0;
		so_next  = found ? so_cur + bcast_pkg::addr_t'(1) - s_sub : '0;

		res.out_index    = lin_cur;
		res.first_index  = fo_cur;
		res.second_index = so_cur;
		res.last         = &wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			lin_q <= '0;
			fo_q  <= '0;
			so_q  <= '0;
		end else if (clr) begin
			pos_q <= '0;
			lin_q <= '0;
			fo_q  <= '0;
			so_q  <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
			lin_q <= lin_next;
			fo_q  <= fo_next;
			so_q  <= so_next;
		end
	end

`ifndef SYNTHESIS
	a_wrap_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.last && !clr |=> lin_q == '0 && fo_q == '0 && so_q == '0)
		else $error("counter does not wrap to zero after the final element");

	a_linear_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !res.last && !clr |=> lin_q == $past(res.out_index) + 1'b1)
		else $error("output index does not advance by one");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> pos_q == '0 && lin_q == '0)
		else $error("register write does not clear the position");
`endif

endmodule
`default_nettype wire

// ===== rtl/bcast_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcast_skid
// Output register with a skid stage so input can be taken while a result
// waits on the output.
// ----------------------------------------------------------------------------
module bcast_skid (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire  bcast_pkg::result_t in_data,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output bcast_pkg::result_t  out_word
);

	logic               main_valid_q, skid_valid_q;
	bcast_pkg::result_t main_q, skid_q;
	logic               main_free;

	assign main_free = !main_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_word  = main_q;

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid stage holds a word while the output is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(main_valid_q && !out_ready && in_valid))
		else $error("skid stage loaded without an output stall");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !in_valid)
		else $error("word offered while the skid stage is full");
`endif

endmodule
`default_nettype wire

// ===== rtl/broadcast_index_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// broadcast_index_generator
// Address generator for a binary elementwise operation with NumPy-style
// broadcasting over four dimensions.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Signals                               Word
// s_       in         s_tvalid s_tready s_tdata[7:0]        step request
// m_       out        m_tvalid m_tready m_tdata m_tlast     three indices + last
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data register write
//
// One step request is taken every cycle while s_tready is high; its result
// reaches m_ through the output register. The counter state feeds a 48-bit
// add and subtract per operand index and a small carry search, so nothing
// limits the rate below one word per clock. A skid stage lets the input keep
// flowing for one word while m_ stalls. A register write holds s_tready low
// while the registered stride products (a 12x12 then a 24x12 multiply) settle.
// Reset sets every extent to one, both keep masks to all ones and the counter
// to element zero; there is no clearing pass.
//
module broadcast_index_generator (
	input  wire                                      clk,
	input  wire                                      arst_n,
	// Bit 0: restart; bits 7:1 unused.
	input  wire  [bcast_pkg::IN_TDATA_BITS-1:0]      s_tdata,
	input  wire                                      s_tvalid,
	output logic                                     s_tready,
	// Bits 47:0 out_index, 95:48 first_index, 143:96 second_index.
	output logic [bcast_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
	output logic                                     m_tlast,
	output logic                                     m_tvalid,
	input  wire                                      m_tready,
	input  wire                                      cfg_valid,
	output logic                                     cfg_ready,
	input  wire  [bcast_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire  bcast_pkg::extent_t                 cfg_data
);

	bcast_pkg::cfg_t    cfg;
	bcast_pkg::stride_t strides;
	bcast_pkg::result_t step_res, out_res;
	logic               busy;
	logic               cfg_wr;
	logic               accept;
	logic               skid_ready;

	// Registers always writable; user writes only when block idle, unenforced.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Input waits while the strides settle, while a write is offered (it
	// clears the counter), and while the skid stage is full.
	assign s_tready = !busy && !cfg_valid && skid_ready;
	assign accept   = s_tvalid && s_tready;

	bcast_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.strides  (strides),
		.busy     (busy)
	);

	// The counter emits the indices of the current element and advances on
	// every accepted word; a restart word emits element zero.
	bcast_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_wr),
		.accept  (accept),
		.restart (s_tdata[0]),
		.cfg     (cfg),
		.strides (strides),
		.res     (step_res)
	);

	bcast_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_data   (step_res),
		.in_ready  (skid_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_res)
	);

	assign m_tdata = {out_res.second_index, out_res.first_index, out_res.out_index};
	assign m_tlast = out_res.last;

`ifndef SYNTHESIS
	a_hold_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !s_tready ##1 !s_tready)
		else $error("input taken before the strides settled");

	a_accept_idle_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy && !cfg_wr)
		else $error("word accepted together with a register update");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted word produced no result");
`endif

endmodule
`default_nettype wire
